// ===== hdl/ctd_pkg.sv =====
// Shared types, codes and helpers for the chunked-transfer decoder.
`timescale 1ns / 1ps

package ctd_pkg;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_LENGTH = 1'b1;

  localparam int unsigned MAX_LINE_W = 10;

  localparam logic [31:0]           MAX_CHUNK_RST = 32'hFFFF_FFFF;
  localparam logic [MAX_LINE_W-1:0] MAX_LINE_RST  = 10'd64;

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_DATA = 3'd1,
    PH_CR   = 3'd2,
    PH_LF   = 3'd3,
    PH_DONE = 3'd4,
    PH_ERR  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    K_FRAME     = 3'd0,
    K_PAYLOAD   = 3'd1,
    K_FINAL     = 3'd2,
    K_AFTER     = 3'd3,
    K_MALFORMED = 3'd4,
    K_TOOBIG    = 3'd5
  } kind_e;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // {valid, value}; valid low for a non-hex byte
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] res;
    res = 5'd0;
    case (ch) inside
      [8'h30:8'h39]: res = {1'b1, ch[3:0]};
      [8'h61:8'h66],
      [8'h41:8'h46]: res = {1'b1, ch[3:0] + 4'd9};
      default:       res = 5'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/ctd_core.sv =====
// Decoder state, configuration registers and the per-byte step logic.
`timescale 1ns / 1ps

module ctd_core #(
  parameter int unsigned SIZE_WIDTH       = 32,
  parameter int unsigned LINE_COUNT_WIDTH = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctd_pkg::cfg_wr_t cfg_i,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             restart_i,
  output logic [7:0]       out_byte_o,
  output ctd_pkg::kind_e   kind_o
);
  import ctd_pkg::*;

  localparam int unsigned SW  = SIZE_WIDTH;
  localparam int unsigned LCW = LINE_COUNT_WIDTH;

  logic [31:0]           max_chunk_q;
  logic [MAX_LINE_W-1:0] max_line_q;

  phase_e         phase_q, phase_d, ph_e;
  logic [SW-1:0]  bytes_left_q, bytes_left_d, bl_e, bl_dec;
  logic [SW-1:0]  size_value_q, size_value_d, sv_e;
  logic [LCW-1:0] line_count_q, line_count_d, lc_e;
  logic in_prefix_q, in_prefix_d, ip_e;
  logic seen_digit_q, seen_digit_d, sd_e;
  logic size_overflow_q, size_overflow_d, ov_e;
  logic bad_tail_q, bad_tail_d, bt_e;
  logic pending_cr_q, pending_cr_d, pc_e;
  logic error_code_q, error_code_d, ec_e;

  // effective limits
  logic [SW+31:0]         chunk_ext;
  logic [SW-1:0]          chunk_lim;
  logic [LCW+MAX_LINE_W-1:0] line_ext;
  logic [LCW-1:0]         line_lim;

  assign chunk_ext = {{SW{1'b0}}, max_chunk_q};
  assign chunk_lim = chunk_ext[SW-1:0];
  assign line_ext  = {{LCW{1'b0}}, max_line_q};
  assign line_lim  = (line_ext > {{MAX_LINE_W{1'b0}}, {LCW{1'b1}}}) ? {LCW{1'b1}}
                                                                     : line_ext[LCW-1:0];

  // restart acts before the byte
  assign ph_e = restart_i ? PH_SIZE : phase_q;
  assign bl_e = restart_i ? '0 : bytes_left_q;
  assign sv_e = restart_i ? '0 : size_value_q;
  assign lc_e = restart_i ? '0 : line_count_q;
  assign ip_e = restart_i ? 1'b1 : in_prefix_q;
  assign sd_e = restart_i ? 1'b0 : seen_digit_q;
  assign ov_e = restart_i ? 1'b0 : size_overflow_q;
  assign bt_e = restart_i ? 1'b0 : bad_tail_q;
  assign pc_e = restart_i ? 1'b0 : pending_cr_q;
  assign ec_e = restart_i ? 1'b0 : error_code_q;

  logic       is_cr, is_lf, is_semi;
  logic [4:0] hex;
  logic [SW+3:0] acc;
  logic       acc_big;

  assign is_cr   = (data_byte_i == CH_CR);
  assign is_lf   = (data_byte_i == CH_LF);
  assign is_semi = (data_byte_i == CH_SEMI);
  assign hex     = hex_value(data_byte_i);
  // size*16 + digit, exact; over the limit means overflow
  assign acc     = {sv_e, 4'd0} + {{SW{1'b0}}, hex[3:0]};
  assign acc_big = (acc > {4'd0, chunk_lim});
  assign bl_dec  = (bl_e != '0) ? bl_e - SW'(1) : bl_e;

  // next state
  always_comb begin
    phase_d         = ph_e;
    bytes_left_d    = bl_e;
    size_value_d    = sv_e;
    line_count_d    = lc_e;
    in_prefix_d     = ip_e;
    seen_digit_d    = sd_e;
    size_overflow_d = ov_e;
    bad_tail_d      = bt_e;
    pending_cr_d    = pc_e;
    error_code_d    = ec_e;
    case (ph_e)
      PH_SIZE: begin
        if (is_lf) begin
          if (!pc_e || (!ov_e && (!sd_e || bt_e))) begin
            phase_d      = PH_ERR;
            error_code_d = 1'b0;
          end else if (ov_e) begin
            phase_d      = PH_ERR;
            error_code_d = 1'b1;
          end else begin
            size_value_d    = '0;
            line_count_d    = '0;
            in_prefix_d     = 1'b1;
            seen_digit_d    = 1'b0;
            size_overflow_d = 1'b0;
            bad_tail_d      = 1'b0;
            pending_cr_d    = 1'b0;
            if (sv_e == '0) begin
              phase_d = PH_DONE;
            end else begin
              phase_d      = PH_DATA;
              bytes_left_d = sv_e;
            end
          end
        end else if (lc_e >= line_lim) begin
          phase_d      = PH_ERR;
          error_code_d = 1'b1;
        end else begin
          line_count_d = lc_e + LCW'(1);
          // a held CR that was not followed by LF is a plain line byte
          in_prefix_d  = ip_e & ~pc_e;
          bad_tail_d   = bt_e | (ip_e & pc_e);
          if (is_cr) begin
            pending_cr_d = 1'b1;
          end else begin
            pending_cr_d = 1'b0;
            if (in_prefix_d) begin
              if (!hex[4]) begin
                in_prefix_d = 1'b0;
                if (!is_semi) begin
                  bad_tail_d = 1'b1;
                end
              end else if (!ov_e) begin
                if (acc_big) begin
                  size_overflow_d = 1'b1;
                end else begin
                  size_value_d = acc[SW-1:0];
                  seen_digit_d = 1'b1;
                end
              end
            end
          end
        end
      end
      PH_DATA: begin
        bytes_left_d = bl_dec;
        if (bl_dec == '0) begin
          phase_d = PH_CR;
        end
      end
      PH_CR: begin
        if (is_cr) begin
          phase_d = PH_LF;
        end else begin
          phase_d      = PH_ERR;
          error_code_d = 1'b0;
        end
      end
      PH_LF: begin
        if (is_lf) begin
          phase_d         = PH_SIZE;
          size_value_d    = '0;
          line_count_d    = '0;
          in_prefix_d     = 1'b1;
          seen_digit_d    = 1'b0;
          size_overflow_d = 1'b0;
          bad_tail_d      = 1'b0;
          pending_cr_d    = 1'b0;
        end else begin
          phase_d      = PH_ERR;
          error_code_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    out_byte_o = 8'd0;
    kind_o     = K_FRAME;
    if (phase_d == PH_ERR) begin
      kind_o = error_code_d ? K_TOOBIG : K_MALFORMED;
    end else begin
      case (ph_e)
        PH_DATA: begin
          out_byte_o = data_byte_i;
          kind_o     = K_PAYLOAD;
        end
        PH_DONE: kind_o = K_AFTER;
        PH_SIZE: kind_o = (phase_d == PH_DONE) ? K_FINAL : K_FRAME;
        default: kind_o = K_FRAME;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_q <= MAX_CHUNK_RST;
      max_line_q  <= MAX_LINE_RST;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_MAX_CHUNK_SIZE:  max_chunk_q <= cfg_i.data;
        CFG_MAX_LINE_LENGTH: max_line_q  <= cfg_i.data[MAX_LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_SIZE;
      bytes_left_q    <= '0;
      size_value_q    <= '0;
      line_count_q    <= '0;
      in_prefix_q     <= 1'b1;
      seen_digit_q    <= 1'b0;
      size_overflow_q <= 1'b0;
      bad_tail_q      <= 1'b0;
      pending_cr_q    <= 1'b0;
      error_code_q    <= 1'b0;
    end else if (step_i) begin
      phase_q         <= phase_d;
      bytes_left_q    <= bytes_left_d;
      size_value_q    <= size_value_d;
      line_count_q    <= line_count_d;
      in_prefix_q     <= in_prefix_d;
      seen_digit_q    <= seen_digit_d;
      size_overflow_q <= size_overflow_d;
      bad_tail_q      <= bad_tail_d;
      pending_cr_q    <= pending_cr_d;
      error_code_q    <= error_code_d;
    end
  end

endmodule

// ===== hdl/ctd_out_stage.sv =====
// Result register with master-side stream handshake.
`timescale 1ns / 1ps

module ctd_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  logic [7:0]     out_byte_i,
  input  ctd_pkg::kind_e kind_i,
  output logic           ready_o,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,
  output logic [2:0]     m_axis_tuser
);
  import ctd_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  kind_e      kind_q;

  assign ready_o = ~valid_q | m_axis_tready;
  assign valid_d = load_i | (valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= out_byte_i;
      kind_q <= kind_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = byte_q;
  assign m_axis_tuser  = kind_q;

endmodule

// ===== hdl/chunked_transfer_decoder.sv =====
// Top level of the chunked-transfer decoder: input register, core, result register.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                  Handshake
// s_axis    in   tdata[7:0] data_byte, tuser[0] restart   tvalid/tready
// m_axis    out  tdata[7:0] out_byte,  tuser[2:0] kind    tvalid/tready
// cfg       in   cfg_idx_i register, cfg_data_i value     cfg_we_i, no wait
//
// One byte in, one result out, one transfer per cycle sustained while m_axis accepts.
// The path runs through the input register, then the step logic into the result register.
// The decoder state advances when a byte moves from the input register to the result
// register; a stalled m_axis holds the result register, and s_axis_tready drops once
// the input register is full as well.
// rst_ni is asynchronous, active low; registers with a reset come up at their reset values and
// the decoder starts in the size-line state.
module chunked_transfer_decoder #(
  parameter int unsigned SIZE_WIDTH       = 32,
  parameter int unsigned LINE_COUNT_WIDTH = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tuser,  // [0] restart
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]                     m_axis_tuser   // [2:0] kind
);
  import ctd_pkg::*;

  cfg_wr_t cfg;
  logic    in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic    in_restart_q;
  logic    out_ready;
  logic    step;
  logic    in_take;
  logic [7:0] core_byte;
  kind_e   core_kind;

  assign cfg = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_data_i};

  // the input register moves on whenever the result register can take it
  assign step          = in_valid_q & out_ready;
  assign s_axis_tready = ~in_valid_q | out_ready;
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign in_valid_d    = in_take | (in_valid_q & ~step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
  end

  ctd_core #(
    .SIZE_WIDTH      (SIZE_WIDTH),
    .LINE_COUNT_WIDTH(LINE_COUNT_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .step_i     (step),
    .data_byte_i(in_byte_q),
    .restart_i  (in_restart_q),
    .out_byte_o (core_byte),
    .kind_o     (core_kind)
  );

  ctd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .out_byte_i   (core_byte),
    .kind_i       (core_kind),
    .ready_o      (out_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
